[design/rse_pkg.sv]
// rse_pkg: field constants, generator coefficients and gf(2^8) helpers
// for the reed-solomon encoder; no dependencies
`timescale 1ns / 1ps

package rse_pkg;

	// number of check symbols and field polynomial (with the x^8 term)
	localparam int CHECK_COUNT = 16;
	localparam logic [8:0] FIELD_POLY = 9'd285;
	localparam int CNT_W = $clog2(CHECK_COUNT);

	typedef logic [7:0] sym_t;
	typedef logic [CHECK_COUNT:0][7:0] gen_t;

	// one absorb transaction into the check register
	typedef struct packed {
		logic en;
		logic clear;
		sym_t sym;
	} absorb_t;

	// multiply two field elements, shift-and-add with reduction
	function automatic sym_t gf_mul(sym_t a, sym_t b);
		logic [8:0] x;
		sym_t acc;
		x = {1'b0, a};
		acc = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				acc = acc ^ x[7:0];
			end
			x = {x[7:0], 1'b0};
			if (x[8]) begin
				x = x ^ FIELD_POLY;
			end
		end
		return acc;
	endfunction

	// generator product of (x + alpha^i), i = 1..CHECK_COUNT; evaluated at elaboration
	function automatic gen_t build_generator();
		gen_t g;
		sym_t root;
		g = '0;
		g[0] = 8'd1;
		root = 8'd1;
		for (int i = 1; i <= CHECK_COUNT; i++) begin
			root = gf_mul(root, 8'd2);
			for (int j = i; j > 0; j--) begin
				g[j] = g[j-1] ^ gf_mul(g[j], root);
			end
			g[0] = gf_mul(g[0], root);
		end
		return g;
	endfunction

	localparam gen_t GEN_COEF = build_generator();

endpackage

[design/rse_lfsr.sv]
// rse_lfsr: check-symbol register with constant-multiplier feedback
// depends on rse_pkg
`timescale 1ns / 1ps

module rse_lfsr (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rse_pkg::absorb_t          absorb,
	input  logic [rse_pkg::CNT_W-1:0] rd_idx,
	output rse_pkg::sym_t             rd_data
);

	rse_pkg::sym_t stage_q [rse_pkg::CHECK_COUNT];
	rse_pkg::sym_t base    [rse_pkg::CHECK_COUNT];
	rse_pkg::sym_t stage_d [rse_pkg::CHECK_COUNT];
	rse_pkg::sym_t fb;

	// first flag clears before absorbing; feedback from the oldest stage
	always_comb begin
		for (int i = 0; i < rse_pkg::CHECK_COUNT; i++) begin
			base[i] = absorb.clear ? '0 : stage_q[i];
		end
		fb = absorb.sym ^ base[0];
		for (int i = 0; i < rse_pkg::CHECK_COUNT - 1; i++) begin
			stage_d[i] = base[i+1] ^
				rse_pkg::gf_mul(rse_pkg::GEN_COEF[rse_pkg::CHECK_COUNT-1-i], fb);
		end
		stage_d[rse_pkg::CHECK_COUNT-1] = rse_pkg::gf_mul(rse_pkg::GEN_COEF[0], fb);
	end

	// stage register, zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rse_pkg::CHECK_COUNT; i++) begin
				stage_q[i] <= '0;
			end
		end else if (absorb.en) begin
			stage_q <= stage_d;
		end
	end

	// read port for check emission
	assign rd_data = stage_q[rd_idx];

endmodule

[design/rs_systematic_encoder_top.sv]
// rs_systematic_encoder_top: systematic reed-solomon encoder over gf(2^8)
// depends on rse_pkg and rse_lfsr
`timescale 1ns / 1ps
//
//  channel   handshake                  payload
//  data      data_valid / data_ready    data_symbol, first_symbol, last_symbol
//  result    result_valid / result_ready out_symbol, is_check, end_of_run
//
// one data symbol is absorbed per cycle while data_ready is high; its echo sits in
// the result register the next cycle. a symbol with the last flag is followed by
// CHECK_COUNT check transactions, one per cycle while the result is not stalled,
// read from the check register; data_ready is low until the final check is loaded.
// reset clears the check stages and the result valid flag. a stalled result
// holds its value; a new symbol is taken while the result is being taken.

module rs_systematic_encoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       data_valid,
	output logic       data_ready,
	input  logic [7:0] data_symbol,
	input  logic       first_symbol,
	input  logic       last_symbol,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [7:0] out_symbol,
	output logic       is_check,
	output logic       end_of_run
);

	logic                      out_valid_q;
	rse_pkg::sym_t             out_symbol_q;
	logic                      is_check_q;
	logic                      end_q;
	logic                      emitting_q;
	logic [rse_pkg::CNT_W-1:0] emit_cnt_q;
	logic                      advance;
	logic                      accept;
	logic                      last_check;
	rse_pkg::absorb_t          absorb;
	rse_pkg::sym_t             check_sym;

	// result register free or being emptied this cycle
	assign advance    = !out_valid_q || result_ready;
	assign data_ready = !emitting_q && advance;
	assign accept     = data_valid && data_ready;
	assign last_check = emit_cnt_q == rse_pkg::CNT_W'(rse_pkg::CHECK_COUNT - 1);

	assign absorb.en    = accept;
	assign absorb.clear = first_symbol;
	assign absorb.sym   = data_symbol;

	rse_lfsr u_lfsr (
		.clk     (clk),
		.arst_n  (arst_n),
		.absorb  (absorb),
		.rd_idx  (emit_cnt_q),
		.rd_data (check_sym)
	);

	// emission control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			emitting_q  <= 1'b0;
			emit_cnt_q  <= '0;
		end else if (emitting_q && advance) begin
			out_valid_q <= 1'b1;
			if (last_check) begin
				emitting_q <= 1'b0;
				emit_cnt_q <= '0;
			end else begin
				emit_cnt_q <= emit_cnt_q + rse_pkg::CNT_W'(1);
			end
		end else if (accept) begin
			out_valid_q <= 1'b1;
			emitting_q  <= last_symbol;
			emit_cnt_q  <= '0;
		end else if (advance) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload: a check symbol or the echoed data symbol
	always_ff @(posedge clk) begin
		if (emitting_q && advance) begin
			out_symbol_q <= check_sym;
			is_check_q   <= 1'b1;
			end_q        <= last_check;
		end else if (accept) begin
			out_symbol_q <= data_symbol;
			is_check_q   <= 1'b0;
			end_q        <= !last_symbol;
		end
	end

	assign result_valid = out_valid_q;
	assign out_symbol   = out_symbol_q;
	assign is_check     = is_check_q;
	assign end_of_run   = end_q;

endmodule

[design/rse_checker.sv]
// rse_checker: port-level assertions for rs_systematic_encoder_top
// bound to the top level below; no package dependencies
`timescale 1ns / 1ps

module rse_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       data_valid,
	input logic       data_ready,
	input logic [7:0] data_symbol,
	input logic       first_symbol,
	input logic       last_symbol,
	input logic       result_valid,
	input logic       result_ready,
	input logic [7:0] out_symbol,
	input logic       is_check,
	input logic       end_of_run
);

	// a pending result stays offered
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped before transaction");

	// every accepted symbol shows its echo next cycle
	a_echo_follows: assert property (@(posedge clk) disable iff (!arst_n)
		data_valid && data_ready |=> result_valid)
		else $error("no result after data transaction");

	// data_ready drops after a symbol with the last flag is accepted
	a_block_during_checks: assert property (@(posedge clk) disable iff (!arst_n)
		data_valid && data_ready && last_symbol |=> !data_ready)
		else $error("data accepted during check emission");

	// a run that has not ended continues with a check symbol
	a_checks_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !end_of_run |=> result_valid && is_check)
		else $error("check sequence broken");

endmodule

bind rs_systematic_encoder_top rse_checker u_rse_checker (.*);
